[rtl/sorted_free_page_list_defines.svh]
// assertion macros of the sorted free page list rtl, used by its top module
`ifndef SORTED_FREE_PAGE_LIST_DEFINES_SVH
`define SORTED_FREE_PAGE_LIST_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define SFPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SFPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// fixed-delay implication
`define SFPL_ASSERT_DLY3(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error("assertion failed");

`endif

[rtl/sfpl_pkg.sv]
// package with types and constants of the sorted free page list
`timescale 1ns / 1ps

package sfpl_pkg;

    // default sizes
    localparam int CAPACITY_DEF  = 64;
    localparam int PAGE_BITS_DEF = 32;

    // fixed field widths of the command and result words
    localparam int PAGE_NUM_W = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    // operation codes
    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2
    } t_status;

    // command word
    typedef struct packed {
        t_cmd                  cmd;
        logic [PAGE_NUM_W-1:0] page_id;
    } t_req;

    // result word
    typedef struct packed {
        t_status               status;
        logic [COUNT_W-1:0]    entry_count;
        logic [PAGE_NUM_W-1:0] lowest_page;
        logic                  is_empty;
    } t_rsp;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

[rtl/sfpl_cell.sv]
// one compare-and-shift cell of the sorted page chain
`timescale 1ns / 1ps

module sfpl_cell #(
    parameter int PAGE_BITS = sfpl_pkg::PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfpl_pkg::t_cell_ctl  i_ctl,
    input  logic [PAGE_BITS-1:0] i_key,
    input  logic [PAGE_BITS-1:0] i_left_page,
    input  logic                 i_left_valid,
    input  logic                 i_left_le,
    input  logic                 i_left_lt,
    input  logic [PAGE_BITS-1:0] i_right_page,
    input  logic                 i_right_valid,
    output logic [PAGE_BITS-1:0] o_page,
    output logic                 o_valid,
    output logic                 o_le,
    output logic                 o_lt,
    output logic                 o_hit
);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic                 r_le;
    logic                 r_lt;
    logic                 r_eq;

    // compare flags against the key, kept for the apply cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_le <= r_valid && (r_page <= i_key);
            r_lt <= r_valid && (r_page <  i_key);
            r_eq <= r_valid && (r_page == i_key);
        end
    end

    // slot contents: keep, take the key, or shift from a neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins && !r_le) begin
            if (i_left_le) begin
                r_page  <= i_key;
                r_valid <= 1'b1;
            end else begin
                r_page  <= i_left_page;
                r_valid <= i_left_valid;
            end
        end else if (i_ctl.rem && !r_lt) begin
            r_page  <= i_right_page;
            r_valid <= i_right_valid;
        end
    end

    // this slot is the first one not below the key and it matches
    assign o_hit   = r_eq && i_left_lt;
    assign o_page  = r_page;
    assign o_valid = r_valid;
    assign o_le    = r_le;
    assign o_lt    = r_lt;

endmodule

[rtl/sorted_free_page_list.sv]
// sorted free page list: sequencer, chain of compare-and-shift cells
// sequence: a word accepted in the idle state passes the compare state and then the
//   apply state, where the cells shift, and its result strobe is registered on leaving it
// flow: a new word is taken only in the idle state, not during the compare or apply
//   state, while busy is high; the receiver cannot stall
// reset: synchronous active low, empties the list and clears every cell valid bit
`timescale 1ns / 1ps
`include "sorted_free_page_list_defines.svh"

module sorted_free_page_list #(
    parameter int CAPACITY  = sfpl_pkg::CAPACITY_DEF,
    parameter int PAGE_BITS = sfpl_pkg::PAGE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sfpl_pkg::t_req i_req,
    output logic           o_done,
    output sfpl_pkg::t_rsp o_rsp
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PAGE_X = (PAGE_BITS > sfpl_pkg::PAGE_NUM_W) ?
                            PAGE_BITS : sfpl_pkg::PAGE_NUM_W;
    localparam int CNT_X  = (CNT_W > sfpl_pkg::COUNT_W) ? CNT_W : sfpl_pkg::COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    t_state                r_state;
    logic                  r_done;
    sfpl_pkg::t_status     r_status;
    sfpl_pkg::t_status     n_status;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    sfpl_pkg::t_cmd        r_cmd;
    logic [PAGE_BITS-1:0]  r_key;

    logic [PAGE_X-1:0]     w_key_x;
    logic [PAGE_X-1:0]     w_low_x;
    logic [CNT_X-1:0]      w_cnt_x;
    logic                  w_full;
    logic                  w_found;
    sfpl_pkg::t_cell_ctl   w_ctl;

    logic [PAGE_BITS-1:0]  w_page  [CAPACITY];
    logic                  w_valid [CAPACITY];
    logic                  w_le    [CAPACITY];
    logic                  w_lt    [CAPACITY];
    logic [CAPACITY-1:0]   w_hit;

    // page number cut or widened to the store width
    assign w_key_x = PAGE_X'(i_req.page_id);

    // command latch
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_req.cmd;
            r_key <= w_key_x[PAGE_BITS-1:0];
        end
    end

    // cell control
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_found   = |w_hit;
    assign w_ctl.cmp = (r_state == S_CMP);
    assign w_ctl.ins = (r_state == S_APPLY) && (r_cmd == sfpl_pkg::CMD_INSERT) && !w_full;
    assign w_ctl.rem = (r_state == S_APPLY) && (r_cmd == sfpl_pkg::CMD_REMOVE) && w_found;

    // cell chain with fixed ends
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [PAGE_BITS-1:0] w_lp;
        logic                 w_lv;
        logic                 w_lle;
        logic                 w_llt;
        logic [PAGE_BITS-1:0] w_rp;
        logic                 w_rv;

        if (g == 0) begin : g_head
            assign w_lp  = '0;
            assign w_lv  = 1'b0;
            assign w_lle = 1'b1;
            assign w_llt = 1'b1;
        end else begin : g_mid_l
            assign w_lp  = w_page[g-1];
            assign w_lv  = w_valid[g-1];
            assign w_lle = w_le[g-1];
            assign w_llt = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_rp = '0;
            assign w_rv = 1'b0;
        end else begin : g_mid_r
            assign w_rp = w_page[g+1];
            assign w_rv = w_valid[g+1];
        end

        sfpl_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_key         (r_key),
            .i_left_page   (w_lp),
            .i_left_valid  (w_lv),
            .i_left_le     (w_lle),
            .i_left_lt     (w_llt),
            .i_right_page  (w_rp),
            .i_right_valid (w_rv),
            .o_page        (w_page[g]),
            .o_valid       (w_valid[g]),
            .o_le          (w_le[g]),
            .o_lt          (w_lt[g]),
            .o_hit         (w_hit[g])
        );
    end

    // status and count after the apply cycle
    always_comb begin
        n_status = sfpl_pkg::ST_DONE;
        n_count  = r_count;
        unique case (r_cmd)
            sfpl_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_status = sfpl_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            sfpl_pkg::CMD_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = sfpl_pkg::ST_NOMATCH;
                end
            end
            default: begin
                n_status = sfpl_pkg::ST_DONE;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_count  <= '0;
            r_status <= sfpl_pkg::ST_DONE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (start) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_state  <= S_IDLE;
                    r_done   <= 1'b1;
                    r_status <= n_status;
                    r_count  <= n_count;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result word, stable during the strobe cycle
    assign w_low_x = PAGE_X'(w_valid[0] ? w_page[0] : '0);
    assign w_cnt_x = CNT_X'(r_count);

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = w_cnt_x[sfpl_pkg::COUNT_W-1:0];
    assign o_rsp.lowest_page = w_low_x[sfpl_pkg::PAGE_NUM_W-1:0];
    assign o_rsp.is_empty    = !w_valid[0];

    // checks
    `SFPL_ASSERT_DLY3(a_done_lat, i_clk, i_rst_n, start && !busy, o_done)
    `SFPL_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, start && !busy, busy)
    `SFPL_ASSERT_IMP(a_empty_cnt, i_clk, i_rst_n, o_done, o_rsp.is_empty == (r_count == '0))
    `SFPL_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))

endmodule
